// File: design/biq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_pkg: shared types and constants for the biquad filter
// Widths of the digit-serial multiply-accumulate path and register indexes.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int COEF_W     = 32;                 // coefficient and state width
  localparam int DIGIT_W    = 4;                  // coefficient bits per cycle
  localparam int N_DIGITS   = COEF_W / DIGIT_W;
  localparam int CNT_W      = $clog2(N_DIGITS);
  localparam int N_LANES    = 3;                  // products summed per pass
  localparam int PP_W       = COEF_W + DIGIT_W + 1;
  localparam int ACC_W      = PP_W + 3;
  localparam int SUM_W      = ACC_W + COEF_W;
  localparam int CFG_ADDR_W = 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FF_COEF_0 = 3'd0,
    CFG_FF_COEF_1 = 3'd1,
    CFG_FF_COEF_2 = 3'd2,
    CFG_FB_COEF_1 = 3'd3,
    CFG_FB_COEF_2 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic load;   // restart accumulation with new coefficients
    logic run;    // consume one coefficient digit
  } mac_ctrl_t;

endpackage
`default_nettype wire

// File: design/biq_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_mac: digit-serial sum of three products
// Coefficients shift in DIGIT_W bits per cycle while run is set, least significant first;
// the accumulator shifts right so the adder stays a few bits over the word.
// ----------------------------------------------------------------------------
module biq_mac #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  biq_pkg::mac_ctrl_t ctrl_i,
  input  biq_pkg::coef_t    coef_i [biq_pkg::N_LANES],
  input  biq_pkg::coef_t    mult_i [biq_pkg::N_LANES],
  output logic              last_o,
  output biq_pkg::sum_t     sum_o
);

  // half an lsb of the scaled result, so the final shift rounds half up
  localparam biq_pkg::acc_t ROUND_INIT = biq_pkg::ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  biq_pkg::coef_t                    coef_sr_q [biq_pkg::N_LANES];
  biq_pkg::acc_t                     acc_q;
  biq_pkg::acc_t                     acc_d;
  logic [biq_pkg::COEF_W-1:0]        low_q;
  logic [biq_pkg::CNT_W-1:0]         cnt_q;
  logic signed [biq_pkg::DIGIT_W:0]  dig [biq_pkg::N_LANES];
  logic signed [biq_pkg::PP_W-1:0]   pp  [biq_pkg::N_LANES];

  assign last_o = (cnt_q == biq_pkg::CNT_W'(biq_pkg::N_DIGITS - 1));

  always_comb begin
    acc_d = acc_q;
    for (int l = 0; l < biq_pkg::N_LANES; l++) begin
      // top digit carries the coefficient sign
      if (last_o) begin
        dig[l] = {coef_sr_q[l][biq_pkg::DIGIT_W-1], coef_sr_q[l][biq_pkg::DIGIT_W-1:0]};
      end else begin
        dig[l] = {1'b0, coef_sr_q[l][biq_pkg::DIGIT_W-1:0]};
      end
      pp[l] = mult_i[l] * dig[l];
      acc_d = acc_d + biq_pkg::ACC_W'(pp[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= '0;
    end else if (ctrl_i.run) begin
      cnt_q <= cnt_q + biq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      coef_sr_q <= coef_i;
      acc_q     <= ROUND_INIT;
      low_q     <= '0;
    end else if (ctrl_i.run) begin
      for (int l = 0; l < biq_pkg::N_LANES; l++) begin
        coef_sr_q[l] <= coef_sr_q[l] >>> biq_pkg::DIGIT_W;
      end
      low_q <= {acc_d[biq_pkg::DIGIT_W-1:0], low_q[biq_pkg::COEF_W-1:biq_pkg::DIGIT_W]};
      acc_q <= acc_d >>> biq_pkg::DIGIT_W;
    end
  end

  assign sum_o = $signed({acc_q, low_q});

endmodule
`default_nettype wire

// File: design/biq_fin.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_fin: scaling and saturation of accumulated sums
// Gives the saturated internal value w and the saturated output sample.
// ----------------------------------------------------------------------------
module biq_fin #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  biq_pkg::sum_t                  sum_i,
  input  biq_pkg::coef_t                 xq_i,
  output biq_pkg::coef_t                 w_o,
  output logic signed [SAMPLE_BITS-1:0]  y_o
);

  localparam int SF  = SAMPLE_BITS - 1;
  localparam int CF  = COEF_FRAC_BITS;
  localparam int D_W = biq_pkg::SUM_W + 1;
  localparam int Y_W = biq_pkg::SUM_W + 8;

  localparam logic signed [D_W-1:0] W_MAX = D_W'(64'sd2147483647);
  localparam logic signed [D_W-1:0] W_MIN = -W_MAX - D_W'(1);
  localparam logic signed [Y_W-1:0] S_MAX = (Y_W'(1) <<< SF) - Y_W'(1);
  localparam logic signed [Y_W-1:0] S_MIN = -S_MAX - Y_W'(1);

  biq_pkg::sum_t          scaled;
  logic signed [D_W-1:0]  diff;
  logic signed [Y_W-1:0]  y_wide;

  // rounding offset was preloaded into the accumulator
  assign scaled = sum_i >>> CF;
  assign diff   = D_W'(xq_i) - D_W'(scaled);

  always_comb begin
    if (diff > W_MAX) begin
      w_o = biq_pkg::COEF_W'(W_MAX);
    end else if (diff < W_MIN) begin
      w_o = biq_pkg::COEF_W'(W_MIN);
    end else begin
      w_o = biq_pkg::COEF_W'(diff);
    end
  end

  generate
    if (CF > SF) begin : g_ydn
      localparam logic signed [Y_W-1:0] Y_HALF = Y_W'(1) <<< (CF - SF - 1);
      assign y_wide = (Y_W'(scaled) + Y_HALF) >>> (CF - SF);
    end else if (CF < SF) begin : g_yup
      assign y_wide = Y_W'(scaled) <<< (SF - CF);
    end else begin : g_yeq
      assign y_wide = Y_W'(scaled);
    end
  endgenerate

  always_comb begin
    if (y_wide > S_MAX) begin
      y_o = SAMPLE_BITS'(S_MAX);
    end else if (y_wide < S_MIN) begin
      y_o = SAMPLE_BITS'(S_MIN);
    end else begin
      y_o = SAMPLE_BITS'(y_wide);
    end
  end

endmodule
`default_nettype wire

// File: design/biquad_iir_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_iir_filter: second-order iir section, direct form ii
// Samples enter on sample_in (valid/ready) and leave on sample_out
// (valid/ready), one result per request. Coefficients are written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i; the user must write them only
// while the filter is idle, which the block itself does not enforce.
// Indexes: 0 ff_coef_0, 1 ff_coef_1, 2 ff_coef_2, 3 fb_coef_1, 4 fb_coef_2,
// other indexes are ignored.
// Each sample runs two passes through one digit-serial multiply-accumulate
// unit that takes 4 coefficient bits per cycle: the feedback sum, a step to
// saturate w, the feedforward sum and a step to round and saturate. A new
// request is taken only once the filter is back in idle after the last step.
// The output register lets a result wait while the next request is taken;
// if it is still full when the next result is ready, the filter holds in
// its last step until the receiver takes the old one.
// Reset gives passthrough coefficients (ff_coef_0 = 1.0), clears the
// delay line and empties the output register.
// ----------------------------------------------------------------------------
module biquad_iir_filter #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [biq_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [biq_pkg::COEF_W-1:0]        cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  input  logic                              sample_in_valid_i,
  output logic                              sample_in_ready_o,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o,
  output logic                              sample_out_valid_o,
  input  logic                              sample_out_ready_i
);

  localparam int SF = SAMPLE_BITS - 1;
  localparam int CF = COEF_FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_MAC,
    ST_FB_FIN,
    ST_FF_MAC,
    ST_FF_FIN
  } state_e;

  state_e                         state_q;
  biq_pkg::coef_t                 ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
  biq_pkg::coef_t                 w1_q, w2_q, w_q, xq_q, xq_d;
  logic signed [SAMPLE_BITS-1:0]  out_q;
  logic                           out_valid_q;

  biq_pkg::mac_ctrl_t             mac_ctrl;
  biq_pkg::coef_t                 mac_coef [biq_pkg::N_LANES];
  biq_pkg::coef_t                 mac_mult [biq_pkg::N_LANES];
  logic                           mac_last;
  biq_pkg::sum_t                  mac_sum;
  biq_pkg::coef_t                 fin_w;
  logic signed [SAMPLE_BITS-1:0]  fin_y;
  logic                           in_take;
  logic                           out_commit;

  // input scaling into the state format
  generate
    if (CF >= SF) begin : g_xup
      assign xq_d = biq_pkg::COEF_W'(sample_in_i) <<< (CF - SF);
    end else begin : g_xdn
      localparam int XW = SAMPLE_BITS + 1;
      localparam logic signed [XW-1:0] X_HALF = XW'(1) <<< (SF - CF - 1);
      logic signed [XW-1:0] x_rnd;
      assign x_rnd = XW'(sample_in_i) + X_HALF;
      assign xq_d  = biq_pkg::COEF_W'(x_rnd >>> (SF - CF));
    end
  endgenerate

  assign sample_in_ready_o  = (state_q == ST_IDLE);
  assign in_take            = sample_in_valid_i && sample_in_ready_o;
  assign out_commit         = (state_q == ST_FF_FIN) && (!out_valid_q || sample_out_ready_i);
  assign sample_out_o       = out_q;
  assign sample_out_valid_o = out_valid_q;

  always_comb begin
    mac_ctrl.load = in_take || (state_q == ST_FB_FIN);
    mac_ctrl.run  = (state_q == ST_FB_MAC) || (state_q == ST_FF_MAC);
    if (state_q == ST_IDLE) begin
      mac_coef[0] = fb1_q;
      mac_coef[1] = fb2_q;
      mac_coef[2] = '0;
    end else begin
      mac_coef[0] = ff0_q;
      mac_coef[1] = ff1_q;
      mac_coef[2] = ff2_q;
    end
    if (state_q == ST_FF_MAC) begin
      mac_mult[0] = w_q;
      mac_mult[1] = w1_q;
      mac_mult[2] = w2_q;
    end else begin
      mac_mult[0] = w1_q;
      mac_mult[1] = w2_q;
      mac_mult[2] = '0;
    end
  end

  biq_mac #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mac_ctrl),
    .coef_i(mac_coef),
    .mult_i(mac_mult),
    .last_o(mac_last),
    .sum_o (mac_sum)
  );

  biq_fin #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_fin (
    .sum_i(mac_sum),
    .xq_i (xq_q),
    .w_o  (fin_w),
    .y_o  (fin_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff0_q <= biq_pkg::COEF_W'(1) <<< CF;
      ff1_q <= '0;
      ff2_q <= '0;
      fb1_q <= '0;
      fb2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        biq_pkg::CFG_FF_COEF_0: ff0_q <= cfg_wdata_i;
        biq_pkg::CFG_FF_COEF_1: ff1_q <= cfg_wdata_i;
        biq_pkg::CFG_FF_COEF_2: ff2_q <= cfg_wdata_i;
        biq_pkg::CFG_FB_COEF_1: fb1_q <= cfg_wdata_i;
        biq_pkg::CFG_FB_COEF_2: fb2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      xq_q        <= '0;
      w_q         <= '0;
      w1_q        <= '0;
      w2_q        <= '0;
    end else begin
      if (sample_out_ready_i && !out_commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            xq_q    <= xq_d;
            state_q <= ST_FB_MAC;
          end
        end
        ST_FB_MAC: begin
          if (mac_last) begin
            state_q <= ST_FB_FIN;
          end
        end
        ST_FB_FIN: begin
          w_q     <= fin_w;
          state_q <= ST_FF_MAC;
        end
        ST_FF_MAC: begin
          if (mac_last) begin
            state_q <= ST_FF_FIN;
          end
        end
        ST_FF_FIN: begin
          // hold here while the previous result is still unread
          if (out_commit) begin
            out_q       <= fin_y;
            out_valid_q <= 1'b1;
            w2_q        <= w1_q;
            w1_q        <= w_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/biq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biq_checker: port-level checks for the biquad filter
// Watches the handshakes on the top level ports.
// ----------------------------------------------------------------------------
module biq_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          sample_in_valid_i,
  input logic                          sample_in_ready_o,
  input logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input logic                          sample_out_valid_o,
  input logic                          sample_out_ready_i
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o && !sample_out_ready_i |=>
      sample_out_valid_o && $stable(sample_out_o))
    else $error("stalled result changed or dropped");

  // one request at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_in_valid_i && sample_in_ready_o |=> !sample_in_ready_o)
    else $error("request taken while a sample is in work");

  // a new result only comes out of a request in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sample_out_valid_o) |-> $past(!sample_in_ready_o))
    else $error("result appeared without a sample in work");

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !sample_out_valid_o)
    else $error("result valid after reset");

endmodule

bind biquad_iir_filter biq_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_biq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .sample_in_valid_i (sample_in_valid_i),
  .sample_in_ready_o (sample_in_ready_o),
  .sample_out_o      (sample_out_o),
  .sample_out_valid_o(sample_out_valid_o),
  .sample_out_ready_i(sample_out_ready_i)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for biquad_iir_filter
// Sends samples in bursts with random gaps and stalls the output side on
// changing patterns. Every filtered sample is checked against a bit-exact
// model of the direct form ii section, kept in step through reset defaults,
// saturating coefficient sets, ignored register writes and random filters.
// ----------------------------------------------------------------------------
module tb_top;
  import biq_pkg::*;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int SFRAC          = SAMPLE_BITS - 1;
  localparam int N_COEFS        = int'(CFG_FB_COEF_2) + 1;
  localparam int N_PHASES       = 12;
  localparam int PHASE_SAMPLES  = 155;
  localparam int BURST_SAMPLES  = 48;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 40;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [127:0]           wide_t;
  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_e;
  typedef enum int {COEF_MODERATE, COEF_FULL, COEF_TINY} coef_kind_e;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t   COEF_ONE   = coef_t'(longint'(1) << COEF_FRAC_BITS);
  localparam wide_t   W_ONE      = 1;

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  cfg_we_i           = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i         = '0;
  logic [COEF_W-1:0]     cfg_wdata_i        = '0;
  sample_t               sample_in_i        = '0;
  logic                  sample_in_valid_i  = 1'b0;
  logic                  sample_in_ready_o;
  sample_t               sample_out_o;
  logic                  sample_out_valid_o;
  logic                  sample_out_ready_i = 1'b0;

  // filter model state
  coef_t       coefs [N_COEFS];
  coef_t       delay_w1;
  coef_t       delay_w2;
  sample_t     expected_samples [$];
  int unsigned mismatches    = 0;
  int unsigned tx_burst_left = 0;

  // receiver stall control
  logic        rx_hold = 1'b0;
  rx_mode_e    rx_mode = RX_STEADY;
  int unsigned rx_left = 0;
  logic [7:0]  rx_mask = 8'h01;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  biquad_iir_filter #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .sample_in_i       (sample_in_i),
    .sample_in_valid_i (sample_in_valid_i),
    .sample_in_ready_o (sample_in_ready_o),
    .sample_out_o      (sample_out_o),
    .sample_out_valid_o(sample_out_valid_o),
    .sample_out_ready_i(sample_out_ready_i)
  );

  function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one step of the section: returns the filtered sample, shifts the delay line
  function automatic sample_t filter_sample(input sample_t x);
    wide_t xs, xq, fb, w, y, d1, d2, half;
    xs   = x;
    d1   = delay_w1;
    d2   = delay_w2;
    half = W_ONE <<< (COEF_FRAC_BITS - 1);
    if (COEF_FRAC_BITS >= SFRAC) begin
      xq = xs <<< (COEF_FRAC_BITS - SFRAC);
    end else begin
      xq = (xs + (W_ONE <<< (SFRAC - COEF_FRAC_BITS - 1))) >>> (SFRAC - COEF_FRAC_BITS);
    end
    fb = (wide_t'(coefs[CFG_FB_COEF_1]) * d1 + wide_t'(coefs[CFG_FB_COEF_2]) * d2 + half)
         >>> COEF_FRAC_BITS;
    w  = clamp(xq - fb, wide_t'(COEF_MIN), wide_t'(COEF_MAX));
    y  = (wide_t'(coefs[CFG_FF_COEF_0]) * w + wide_t'(coefs[CFG_FF_COEF_1]) * d1
          + wide_t'(coefs[CFG_FF_COEF_2]) * d2 + half) >>> COEF_FRAC_BITS;
    if (COEF_FRAC_BITS > SFRAC) begin
      y = clamp(y, -(W_ONE <<< 60), W_ONE <<< 60);
      y = (y + (W_ONE <<< (COEF_FRAC_BITS - SFRAC - 1))) >>> (COEF_FRAC_BITS - SFRAC);
    end else if (COEF_FRAC_BITS < SFRAC) begin
      y = clamp(y, -(W_ONE <<< 40), W_ONE <<< 40);
      y = y <<< (SFRAC - COEF_FRAC_BITS);
    end
    y = clamp(y, wide_t'(SAMPLE_MIN), wide_t'(SAMPLE_MAX));
    delay_w2 = delay_w1;
    delay_w1 = coef_t'(w);
    return sample_t'(y);
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2:    return sample_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t random_coef(input coef_kind_e kind);
    case (kind)
      COEF_MODERATE: return coef_t'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
      COEF_TINY:     return coef_t'(int'($urandom_range(0, 8191)) - 4096);
      default:       return coef_t'($urandom);
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_sample(input sample_t x, input bit bursty);
    int unsigned gap;
    if (bursty && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        sample_in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (tx_burst_left != 0) tx_burst_left--;
    sample_in_i       <= x;
    sample_in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!sample_in_ready_o);
    expected_samples.push_back(filter_sample(x));
  endtask

  // only while idle; with poke_unused, unused indexes are written after the real ones to catch aliasing
  task automatic program_coefs(input coef_t a0, input coef_t a1, input coef_t a2,
                               input coef_t b1, input coef_t b2, input bit poke_unused);
    coef_t vals [N_COEFS];
    vals[CFG_FF_COEF_0] = a0;
    vals[CFG_FF_COEF_1] = a1;
    vals[CFG_FF_COEF_2] = a2;
    vals[CFG_FB_COEF_1] = b1;
    vals[CFG_FB_COEF_2] = b2;
    for (int i = 0; i < N_COEFS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= CFG_ADDR_W'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      coefs[i] = vals[i];
    end
    if (poke_unused) begin
      for (int i = N_COEFS; i < (1 << CFG_ADDR_W); i++) begin
        cfg_addr_i  <= CFG_ADDR_W'(i);
        cfg_wdata_i <= $urandom;
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    sample_in_valid_i <= 1'b0;
    tx_burst_left = 0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_passthrough();
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(24'h555555), 1'b0);
    send_sample(sample_t'(24'haaaaaa), 1'b0);
    wait_idle();
  endtask

  // extreme coefficients drive state and output into saturation; a milder set pokes unused indexes
  task automatic test_saturation();
    program_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    wait_idle();
    program_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    wait_idle();
    program_coefs(COEF_ONE, COEF_ONE >>> 1, -(COEF_ONE >>> 2), COEF_ONE >>> 3,
                  COEF_ONE >>> 4, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_filters();
    coef_kind_e kind;
    for (int p = 0; p < N_PHASES; p++) begin
      kind = coef_kind_e'($urandom_range(0, 2));
      program_coefs(random_coef(kind), random_coef(kind), random_coef(kind),
                    random_coef(kind), random_coef(kind), bit'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_SAMPLES; n++) send_sample(random_sample(), 1'b1);
      wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    program_coefs(random_coef(COEF_MODERATE), random_coef(COEF_MODERATE),
                  random_coef(COEF_MODERATE), random_coef(COEF_TINY),
                  random_coef(COEF_TINY), 1'b0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    for (int n = 0; n < BURST_SAMPLES; n++) send_sample(random_sample(), 1'b0);
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 300);
      rx_mask = 8'($urandom) | 8'h01;
    end else begin
      rx_left--;
    end
    rx_mask = {rx_mask[6:0], rx_mask[7]};
    case (rx_mode)
      RX_STEADY: sample_out_ready_i <= !rx_hold;
      RX_RANDOM: sample_out_ready_i <= !rx_hold && ($urandom_range(0, 3) != 0);
      default:   sample_out_ready_i <= !rx_hold && rx_mask[0];
    endcase
  end

  always @(posedge clk_i) begin : check_results
    sample_t want;
    if (rst_ni && sample_out_valid_o && sample_out_ready_i) begin
      if (expected_samples.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: sample_out %0d with nothing expected", $time, sample_out_o);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_out_o !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: sample_out expected %0d got %0d", $time, want, sample_out_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    coefs[CFG_FF_COEF_0] = COEF_ONE;
    coefs[CFG_FF_COEF_1] = '0;
    coefs[CFG_FF_COEF_2] = '0;
    coefs[CFG_FB_COEF_1] = '0;
    coefs[CFG_FB_COEF_2] = '0;
    delay_w1 = '0;
    delay_w2 = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_saturation();
    test_random_filters();
    test_output_backpressure();
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, expected_samples.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
design/biq_pkg.sv
design/biq_mac.sv
design/biq_fin.sv
design/biquad_iir_filter.sv
design/biq_checker.sv
tb/sv/tb_top.sv
